>>> design/cel_pkg.sv
// package: types, constants and helpers for the cross-entropy loss block
`default_nettype none
package cel_pkg;

  localparam int unsigned MaxClassesDef   = 1024;
  localparam int unsigned MaxBatchDef     = 65536;
  localparam int unsigned ProbFracBitsDef = 24;

  localparam int unsigned ProbW  = 25;
  localparam int unsigned ClassW = 10;
  localparam int unsigned LossW  = 21;
  localparam int unsigned SumW   = 37;
  localparam int unsigned LogFrac = 20;

  localparam logic [LossW-1:0] LossMax = {LossW{1'b1}};
  localparam logic [31:0]      Ln2Q32  = 32'd2977044472;

  localparam logic [ProbW-1:0] ClipLowRst  = 25'd2;
  localparam logic [ProbW-1:0] ClipHighRst = 25'd16777214;

  localparam logic [1:0] RegLabelMode = 2'd0;
  localparam logic [1:0] RegClipLow   = 2'd1;
  localparam logic [1:0] RegClipHigh  = 2'd2;

  typedef struct packed {
    logic [ProbW-1:0]  prob;
    logic [ProbW-1:0]  target;
    logic [ClassW-1:0] true_class;
    logic              row_end;
    logic              batch_end;
  } cel_in_t;

  typedef struct packed {
    logic [LossW-1:0] loss;
    logic             is_mean;
    logic             saturated;
    logic             last;
  } cel_out_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // accept beat into the accumulator
    logic log_start;  // load log unit from row accumulator
    logic log_step;   // one squaring step
    logic log_fin;    // form loss, update sum/count
    logic div_start;
    logic div_step;
    logic batch_clr;
  } cel_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic log_done;
    logic div_done;
  } cel_sts_t;

endpackage
`default_nettype wire

>>> design/cel_ctrl.sv
// controller: sequences accumulate, log and mean phases, drives output register
`default_nettype none
module cel_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              row_end,
  input  wire logic              batch_end,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      cel_pkg::cel_cmd_t cmd,
  input  wire cel_pkg::cel_sts_t sts,
  output      logic              sel_mean,
  output      logic              out_load,
  output      logic              out_last
);
  import cel_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOG  = 6'b000010,
    S_LOUT = 6'b000100,
    S_DIV  = 6'b001000,
    S_MOUT = 6'b010000,
    S_WAIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_batch_r, pend_batch_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    pend_batch_nxt = pend_batch_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd            = '0;
    sel_mean       = 1'b0;
    out_load       = 1'b0;
    out_last       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.take       = 1'b1;
          pend_batch_nxt = batch_end;
          if (row_end) begin
            cmd.log_start = 1'b1;
            state_nxt     = S_LOG;
          end else if (batch_end) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        if (sts.log_done) begin
          state_nxt = S_LOUT;
        end
      end
      S_LOUT: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.log_fin   = 1'b1;
          out_load      = 1'b1;
          out_last      = !pend_batch_r;
          out_valid_nxt = 1'b1;
          if (pend_batch_r) begin
            state_nxt = S_WAIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WAIT: begin
        // sum/count updated last cycle, start the mean
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_MOUT;
        end
      end
      S_MOUT: begin
        if (!(out_valid_r && out_stall)) begin
          sel_mean       = 1'b1;
          out_load       = 1'b1;
          out_last       = 1'b1;
          out_valid_nxt  = 1'b1;
          cmd.batch_clr  = 1'b1;
          pend_batch_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_batch_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_batch_r <= pend_batch_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("output overwritten while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOUT) |-> pend_batch_r || $past(state_r) == S_DIV ||
      $past(state_r) == S_MOUT)
    else $error("mean without batch end");

endmodule
`default_nettype wire

>>> design/cel_dp.sv
// datapath: clip, row accumulate, iterative log2, batch sum and serial divider
`default_nettype none
module cel_dp #(
  parameter int unsigned MAX_CLASSES    = cel_pkg::MaxClassesDef,
  parameter int unsigned MAX_BATCH      = cel_pkg::MaxBatchDef,
  parameter int unsigned PROB_FRAC_BITS = cel_pkg::ProbFracBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cel_pkg::cel_in_t              in_data,
  input  wire logic                          label_mode,
  input  wire logic [cel_pkg::ProbW-1:0]     clip_low,
  input  wire logic [cel_pkg::ProbW-1:0]     clip_high,
  input  wire cel_pkg::cel_cmd_t             cmd,
  output      cel_pkg::cel_sts_t             sts,
  input  wire logic                          sel_mean,
  input  wire logic                          out_load,
  input  wire logic                          out_last,
  output      cel_pkg::cel_out_t             out_data
);
  import cel_pkg::*;

  localparam int unsigned ColW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BATCH + 1);
  localparam int unsigned NegW  = 32;  // (F+24)*2^20 fits
  localparam int unsigned IterW = 6;

  logic [ColW-1:0]   col_r, col_nxt;
  logic [ProbW-1:0]  acc_r, acc_nxt;
  logic [SumW-1:0]   sum_r;
  logic [CntW-1:0]   cnt_r;
  logic [ProbW-1:0]  clipped;
  logic [2*ProbW-1:0] prod;
  logic [ProbW:0]    acc_add;
  logic              col_hit;

  always_comb begin
    clipped = in_data.prob;
    if (clipped < clip_low)  clipped = clip_low;
    if (clipped > clip_high) clipped = clip_high;
  end

  assign prod    = clipped * in_data.target;
  assign acc_add = {1'b0, acc_r} + (ProbW+1)'(prod >> PROB_FRAC_BITS);
  assign col_hit = (ClassW'(col_r) == in_data.true_class) &&
                   ((ColW <= ClassW) || (col_r >> ClassW) == '0);

  always_comb begin
    acc_nxt = acc_r;
    col_nxt = col_r;
    if (cmd.take) begin
      if (label_mode) begin
        acc_nxt = acc_add[ProbW] ? {ProbW{1'b1}} : acc_add[ProbW-1:0];
      end else if (col_hit) begin
        acc_nxt = clipped;
      end
      if (in_data.row_end || in_data.batch_end) begin
        col_nxt = '0;
      end else if (32'(col_r) == MAX_CLASSES - 1) begin
        col_nxt = '0;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // log unit: mantissa Q1.30, one squaring per cycle
  logic [31:0]      man_r;
  logic [4:0]       pos_r;
  logic [LogFrac-1:0] frac_r;
  logic [IterW-1:0] it_r;
  logic             zero_r;
  logic [4:0]       top_n;
  logic [63:0]      sq;
  logic [33:0]      sqs;
  logic [NegW-1:0]  neg;
  logic             neg_pos;
  logic [63:0]      lprod;
  logic [LossW-1:0] row_loss;

  // top bit of the value being loaded
  always_comb begin
    top_n = '0;
    for (int i = 0; i < ProbW; i++) begin
      if (acc_nxt[i]) top_n = 5'(i);
    end
  end

  assign sq  = man_r * man_r;
  assign sqs = sq[63:30];

  // neg = F*2^20 - (p*2^20 + frac)
  logic [NegW:0] negfull;
  assign negfull = {1'b0, NegW'(PROB_FRAC_BITS) << LogFrac} -
                   {1'b0, (NegW'(pos_r) << LogFrac) | NegW'(frac_r)};
  assign neg_pos = !negfull[NegW] && (negfull[NegW-1:0] != '0);
  assign neg     = negfull[NegW-1:0];
  assign lprod   = neg * Ln2Q32;
  always_comb begin
    logic [64:0] rnd;
    rnd = {1'b0, lprod} + 65'(64'd1 << 35);
    if (zero_r)                     row_loss = LossMax;
    else if (!neg_pos)              row_loss = '0;
    else if (rnd[64:36] > 29'(LossMax)) row_loss = LossMax;
    else                            row_loss = rnd[36+LossW-1:36];
  end

  always_ff @(posedge clk) begin
    if (cmd.log_start) begin
      man_r  <= 32'(acc_nxt) << (5'd30 - top_n);
      pos_r  <= top_n;
      frac_r <= '0;
      it_r   <= '0;
      zero_r <= (acc_nxt == '0);
    end else if (cmd.log_step && it_r != IterW'(LogFrac)) begin
      it_r <= it_r + 1'b1;
      if (sqs[31] || sqs[33:32] != '0) begin
        man_r  <= sqs[32:1];
        frac_r <= {frac_r[LogFrac-2:0], 1'b1};
      end else begin
        man_r  <= sqs[31:0];
        frac_r <= {frac_r[LogFrac-2:0], 1'b0};
      end
    end
  end

  assign sts.log_done = (it_r == IterW'(LogFrac));

  // divider: restoring, one quotient bit per cycle
  localparam int unsigned DivW = SumW + 1;
  localparam int unsigned DItW = $clog2(DivW + 1);
  logic [DivW-1:0] dnum_r;
  logic [DivW-1:0] drem_r;
  logic [CntW-1:0] dden_r;
  logic [DItW-1:0] dit_r;
  logic [DivW:0]   dtry;
  logic [DivW-1:0] dnum_q;
  logic            dzero_r;
  logic [LossW-1:0] mean;

  assign dtry = {drem_r, dnum_r[DivW-1]} - (DivW+1)'(dden_r);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dnum_r  <= DivW'(sum_r) + DivW'(cnt_r >> 1);
      dden_r  <= cnt_r;
      drem_r  <= '0;
      dit_r   <= '0;
      dzero_r <= (cnt_r == '0);
    end else if (cmd.div_step && dit_r != DItW'(DivW)) begin
      dit_r <= dit_r + 1'b1;
      if (!dtry[DivW]) begin
        drem_r <= dtry[DivW-1:0];
        dnum_r <= {dnum_r[DivW-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[DivW-2:0], dnum_r[DivW-1]};
        dnum_r <= {dnum_r[DivW-2:0], 1'b0};
      end
    end
  end

  assign sts.div_done = (dit_r == DItW'(DivW));
  assign dnum_q = dnum_r;
  assign mean   = dzero_r ? '0 :
                  (dnum_q > DivW'(LossMax)) ? LossMax : dnum_q[LossW-1:0];

  // sum and count
  logic [SumW:0] sum_add;
  assign sum_add = {1'b0, sum_r} + (SumW+1)'(row_loss);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      acc_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      col_r <= col_nxt;
      if (cmd.take && (in_data.row_end || in_data.batch_end) && !in_data.row_end) begin
        acc_r <= '0;
      end else if (cmd.log_fin) begin
        acc_r <= '0;
      end else begin
        acc_r <= acc_nxt;
      end
      if (cmd.batch_clr) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (cmd.log_fin) begin
        sum_r <= sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
        if (32'(cnt_r) < MAX_BATCH) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.loss      <= sel_mean ? mean : row_loss;
      out_data.is_mean   <= sel_mean;
      out_data.saturated <= !sel_mean && zero_r;
      out_data.last      <= out_last;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.log_fin |-> sts.log_done)
    else $error("loss taken before log finished");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_start && cmd.log_fin) |-> 1'b0)
    else $error("mean started during sum update");
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_BATCH)
    else $error("sample count overflow");

endmodule
`default_nettype wire

>>> design/cel_cfg.sv
// configuration register file on the apb-style port
`default_nettype none
module cel_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [3:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready,
  output      logic                      label_mode,
  output      logic [cel_pkg::ProbW-1:0] clip_low,
  output      logic [cel_pkg::ProbW-1:0] clip_high
);
  import cel_pkg::*;

  logic             mode_r;
  logic [ProbW-1:0] low_r, high_r;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      low_r  <= ClipLowRst;
      high_r <= ClipHighRst;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegLabelMode: mode_r <= pwdata[0];
        RegClipLow:   low_r  <= pwdata[ProbW-1:0];
        RegClipHigh:  high_r <= pwdata[ProbW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegLabelMode: prdata = {31'b0, mode_r};
      RegClipLow:   prdata = {7'b0, low_r};
      RegClipHigh:  prdata = {7'b0, high_r};
      default:      prdata = '0;
    endcase
  end

  assign label_mode = mode_r;
  assign clip_low   = low_r;
  assign clip_high  = high_r;

endmodule
`default_nettype wire

>>> design/cross_entropy_loss_forward.sv
// top level: cross-entropy loss forward, streaming probabilities in, losses out
//
// channel | ports                          | payload
// in      | in_valid, in_stall, in_data    | prob, target, true_class, row_end, batch_end
// out     | out_valid, out_stall, out_data | loss, is_mean, saturated, last
// cfg     | cfg_psel .. cfg_pready         | label_mode, clip_low, clip_high
//
// a beat without row_end or batch_end leaves the controller idle, ready for another beat
// row end: the 20-step squaring log unit runs, then the loss is loaded for output
// batch end: the 38-step serial divider runs, then the mean is loaded for output
// row end with batch end: the loss is loaded, then the divider forms the mean
// input stalls while a loss or mean is computed or the output register is held
// synchronous active-low reset clears counters and sums, no clearing pass
`default_nettype none
module cross_entropy_loss_forward #(
  parameter int unsigned MAX_CLASSES    = cel_pkg::MaxClassesDef,
  parameter int unsigned MAX_BATCH      = cel_pkg::MaxBatchDef,
  parameter int unsigned PROB_FRAC_BITS = cel_pkg::ProbFracBitsDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire cel_pkg::cel_in_t in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      cel_pkg::cel_out_t out_data,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [3:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output      logic [31:0]      cfg_prdata,
  output      logic             cfg_pready
);
  import cel_pkg::*;

  cel_cmd_t         cmd;
  cel_sts_t         sts;
  logic             sel_mean, out_load, out_last;
  logic             label_mode;
  logic [ProbW-1:0] clip_low, clip_high;

  cel_cfg u_cfg (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready),
    .label_mode, .clip_low, .clip_high
  );

  cel_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .row_end(in_data.row_end), .batch_end(in_data.batch_end),
    .out_valid, .out_stall, .cmd, .sts, .sel_mean, .out_load, .out_last
  );

  cel_dp #(
    .MAX_CLASSES(MAX_CLASSES), .MAX_BATCH(MAX_BATCH),
    .PROB_FRAC_BITS(PROB_FRAC_BITS)
  ) u_dp (
    .clk, .rst_n, .in_data, .label_mode, .clip_low, .clip_high,
    .cmd, .sts, .sel_mean, .out_load, .out_last, .out_data
  );

endmodule
`default_nettype wire
